// File: src/shlp_pkg.sv
`default_nettype none
package shlp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 524288;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned MOD_W      = 22;
  localparam int unsigned SLOTS_W    = 20;
  localparam int unsigned SLOT_OUT_W = 19;
  localparam int unsigned TRIES_W    = 20;
  localparam int unsigned COLL_W     = 32;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_HASH_SELECT  = 2'd0;
  localparam logic [1:0] REG_TERM_MODULUS = 2'd1;
  localparam logic [1:0] REG_TABLE_SLOTS  = 2'd2;

  // hash variants
  localparam logic [SEL_W-1:0] HS_PROD_POW = 2'd0;
  localparam logic [SEL_W-1:0] HS_POW53    = 2'd1;
  localparam logic [SEL_W-1:0] HS_POW31    = 2'd2;

  localparam logic [SEL_W-1:0]   HASH_SEL_RST  = HS_PROD_POW;
  localparam logic [MOD_W-1:0]   TERM_MOD_RST  = 22'd500000;
  localparam logic [SLOTS_W-1:0] SLOTS_RST     = 20'd500000;

  localparam logic [SUM_W-1:0] MUL_31 = 32'd31;
  localparam logic [SUM_W-1:0] MUL_53 = 32'd53;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POW,
    ST_MULC,
    ST_TMOD,
    ST_ACC,
    ST_HSTART,
    ST_HDIV,
    ST_PRD,
    ST_PCHK,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: src/string_hash_linear_probe_insert_core.sv
`default_nettype none
// one item in flight: a kept character raises its base to the power of its position by square
// and multiply, then, when term_modulus is non-zero, reduces the term in the shared serial
// remainder unit (one bit a cycle); a repeated character adds nothing; a last character
// then finds the start slot in the same unit and probes the occupancy memory (registered read)
// reset: the occupancy memory is swept clear one slot a cycle, during which no item is taken;
// configuration writes are taken at any time
module string_hash_linear_probe_insert_core #(
  parameter int unsigned TABLE_DEPTH = shlp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input characters
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [shlp_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic                             last_char_i,
  // results
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [shlp_pkg::SLOT_OUT_W-1:0]       slot_index_o,
  output logic [shlp_pkg::TRIES_W-1:0]          tries_o,
  output logic [shlp_pkg::COLL_W-1:0]           collisions_total_o,
  output logic [shlp_pkg::TRIES_W-1:0]          max_tries_o,
  output logic                                  table_full_o,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [shlp_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [shlp_pkg::DATA_W-1:0]      pwdata,
  output logic [shlp_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import shlp_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;   // counts up to the table depth and one more

  state_e state_q, state_d;

  // configuration registers
  logic [SEL_W-1:0]   hash_sel_q;
  logic [MOD_W-1:0]   term_mod_q;
  logic [SLOTS_W-1:0] slots_q;

  // word state
  logic [SUM_W-1:0]  hash_sum_q, hash_sum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CHAR_W-1:0] prev_char_q, prev_char_d;
  logic              prev_valid_q, prev_valid_d;

  // current character and power evaluation
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [SUM_W-1:0]  pw_acc_q, pw_acc_d;
  logic [SUM_W-1:0]  pw_base_q, pw_base_d;
  logic [POS_W-1:0]  exp_q, exp_d;
  logic              phase_q, phase_d;
  logic [SUM_W-1:0]  term_q, term_d;
  logic [SUM_W-1:0]  term_val;

  // shared multiplier, low 32 bits only
  logic [SUM_W-1:0]  mul_a, mul_b, mul_p;

  // probe state
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     n_clamp;
  logic [SUM_W-1:0]  slots_ext;
  logic [AW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     slot_inc;
  logic [CW-1:0]     t_q, t_d;
  logic              found_q, found_d;
  logic [COLL_W-1:0] coll_q, coll_d;
  logic [CW-1:0]     max_q, max_d;
  logic [AW-1:0]     clr_q, clr_d;

  // occupancy memory
  logic              mem_q [TABLE_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic              mem_wd;
  logic              rd_q;

  // remainder unit
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [MOD_W-1:0]  div_divisor;
  logic              div_done;
  logic [MOD_W-1:0]  div_rem;

  // output register
  logic                  out_load;
  logic                  out_valid_q, out_valid_d;
  logic [SLOT_OUT_W-1:0] slot_out_q;
  logic [TRIES_W-1:0]    tries_out_q;
  logic [COLL_W-1:0]     coll_out_q;
  logic [TRIES_W-1:0]    max_out_q;
  logic                  full_out_q;
  logic [31:0]           slot_ext, t_ext, max_ext;

  logic cfg_wr;

  shlp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_sel_q <= HASH_SEL_RST;
      term_mod_q <= TERM_MOD_RST;
      slots_q    <= SLOTS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HASH_SELECT:  hash_sel_q <= pwdata[SEL_W-1:0];
        REG_TERM_MODULUS: term_mod_q <= pwdata[MOD_W-1:0];
        REG_TABLE_SLOTS:  slots_q    <= pwdata[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HASH_SELECT:  prdata = DATA_W'(hash_sel_q);
      REG_TERM_MODULUS: prdata = DATA_W'(term_mod_q);
      REG_TABLE_SLOTS:  prdata = DATA_W'(slots_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  assign mul_p = mul_a * mul_b;

  // slot count in use, limited to 1..TABLE_DEPTH
  assign slots_ext = 32'(slots_q);
  always_comb begin
    if (slots_q == '0) begin
      n_clamp = CW'(1);
    end else if (slots_ext > 32'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = CW'(slots_q);
    end
  end

  assign slot_inc = CW'(slot_q) + 1'b1;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    hash_sum_d   = hash_sum_q;
    pos_d        = pos_q;
    prev_char_d  = prev_char_q;
    prev_valid_d = prev_valid_q;
    char_d       = char_q;
    last_d       = last_q;
    pw_acc_d     = pw_acc_q;
    pw_base_d    = pw_base_q;
    exp_d        = exp_q;
    phase_d      = phase_q;
    term_d       = term_q;
    n_d          = n_q;
    slot_d       = slot_q;
    t_d          = t_q;
    found_d      = found_q;
    coll_d       = coll_q;
    max_d        = max_q;
    clr_d        = clr_q;
    mul_a        = pw_acc_q;
    mul_b        = pw_base_q;
    term_val     = pw_acc_q;
    div_start    = 1'b0;
    div_dividend = hash_sum_q + 1'b1;
    div_divisor  = term_mod_q;
    mem_we       = 1'b0;
    mem_wa       = slot_q;
    mem_wd       = 1'b1;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 1'b0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          char_d = char_code_i;
          last_d = last_char_i;
          if (prev_valid_q && (prev_char_q == char_code_i)) begin
            // repeated character adds nothing
            if (last_char_i) begin
              state_d = ST_HSTART;
            end
          end else begin
            pw_acc_d = 32'd1;
            exp_d    = pos_q;
            phase_d  = 1'b0;
            state_d  = ST_POW;
            unique case (hash_sel_q)
              HS_PROD_POW: pw_base_d = 32'(char_code_i) * MUL_31;
              HS_POW53:    pw_base_d = MUL_53;
              HS_POW31:    pw_base_d = MUL_31;
              default: begin
                term_d  = '0;
                state_d = ST_ACC;
              end
            endcase
          end
        end
      end

      // square and multiply, one product a cycle
      ST_POW: begin
        if (!phase_q) begin
          if (exp_q == '0) begin
            state_d = ST_MULC;
          end else begin
            if (exp_q[0]) begin
              pw_acc_d = mul_p;
            end
            phase_d = 1'b1;
          end
        end else begin
          mul_a     = pw_base_q;
          pw_base_d = mul_p;
          exp_d     = exp_q >> 1;
          phase_d   = 1'b0;
        end
      end

      ST_MULC: begin
        mul_a = pw_acc_q;
        mul_b = 32'(char_q);
        if (hash_sel_q != HS_PROD_POW) begin
          term_val = mul_p;
        end
        term_d = term_val;
        if (term_mod_q != '0) begin
          div_start    = 1'b1;
          div_dividend = term_val;
          state_d      = ST_TMOD;
        end else begin
          state_d = ST_ACC;
        end
      end

      ST_TMOD: begin
        if (div_done) begin
          term_d  = 32'(div_rem);
          state_d = ST_ACC;
        end
      end

      ST_ACC: begin
        hash_sum_d   = hash_sum_q + term_q;
        pos_d        = pos_q + 1'b1;
        prev_char_d  = char_q;
        prev_valid_d = 1'b1;
        state_d      = last_q ? ST_HSTART : ST_IDLE;
      end

      ST_HSTART: begin
        n_d          = n_clamp;
        div_start    = 1'b1;
        div_divisor  = MOD_W'(n_clamp);
        state_d      = ST_HDIV;
      end

      ST_HDIV: begin
        if (div_done) begin
          slot_d  = AW'(div_rem);
          t_d     = CW'(1);
          state_d = ST_PRD;
        end
      end

      // memory read of slot_q is under way
      ST_PRD: begin
        state_d = ST_PCHK;
      end

      ST_PCHK: begin
        if (!rd_q) begin
          mem_we  = 1'b1;
          found_d = 1'b1;
          state_d = ST_FIN;
        end else begin
          if (coll_q != '1) begin
            coll_d = coll_q + 1'b1;
          end
          t_d = t_q + 1'b1;
          if (t_q == n_q) begin
            found_d = 1'b0;
            state_d = ST_FIN;
          end else begin
            slot_d  = (slot_inc == n_q) ? '0 : AW'(slot_inc);
            state_d = ST_PRD;
          end
        end
      end

      ST_FIN: begin
        if (t_q > max_q) begin
          max_d = t_q;
        end
        hash_sum_d   = '0;
        pos_d        = '0;
        prev_valid_d = 1'b0;
        state_d      = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      hash_sum_q   <= '0;
      pos_q        <= '0;
      prev_char_q  <= '0;
      prev_valid_q <= 1'b0;
      coll_q       <= '0;
      max_q        <= CW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      hash_sum_q   <= hash_sum_d;
      pos_q        <= pos_d;
      prev_char_q  <= prev_char_d;
      prev_valid_q <= prev_valid_d;
      coll_q       <= coll_d;
      max_q        <= max_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= char_d;
    last_q    <= last_d;
    pw_acc_q  <= pw_acc_d;
    pw_base_q <= pw_base_d;
    exp_q     <= exp_d;
    phase_q   <= phase_d;
    term_q    <= term_d;
    n_q       <= n_d;
    slot_q    <= slot_d;
    t_q       <= t_d;
    found_q   <= found_d;
  end

  // occupancy bits, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[slot_q];
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  assign slot_ext = 32'(slot_q);
  assign t_ext    = 32'(t_q);
  assign max_ext  = 32'(max_q);

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      slot_out_q  <= found_q ? slot_ext[SLOT_OUT_W-1:0] : '0;
      tries_out_q <= t_ext[TRIES_W-1:0];
      coll_out_q  <= coll_q;
      max_out_q   <= max_ext[TRIES_W-1:0];
      full_out_q  <= ~found_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slot_index_o       = slot_out_q;
  assign tries_o            = tries_out_q;
  assign collisions_total_o = coll_out_q;
  assign max_tries_o        = max_out_q;
  assign table_full_o       = full_out_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PCHK) |-> (CW'(slot_q) < n_q))
    else $error("probe slot beyond slots in use");

  a_coll_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (coll_q >= $past(coll_q)))
    else $error("collision total went down");

  a_max_covers_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (t_q <= max_q))
    else $error("max tries below this word's tries");

endmodule
`default_nettype wire

// File: src/shlp_divider.sv
`default_nettype none
module shlp_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [shlp_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic [shlp_pkg::MOD_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [shlp_pkg::MOD_W-1:0]       rem_o
);
  import shlp_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] dvd_q;
  logic [MOD_W-1:0] dvs_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W-1:0] rem_nxt;
  logic [MOD_W:0]   trial;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial = {rem_q, dvd_q[SUM_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_nxt = MOD_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_nxt = MOD_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_nxt;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire
